/* rtl/core/drs_pkg.sv */
// drs_pkg: shared types, widths and codes of the disk request scheduler
`default_nettype none
package drs_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int BLOCK_BITS   = 16;
    localparam int TAG_BITS     = 8;
    localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_BITS     = 32;
    localparam int KIND_BITS    = 2;
    localparam int POLICY_BITS  = 2;
    localparam int BLKCNT_BITS  = 17;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = BLKCNT_BITS;
    localparam int CMP_BITS     = (BLOCK_BITS + 1 > BLKCNT_BITS) ? BLOCK_BITS + 1 : BLKCNT_BITS;

    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [KIND_BITS-1:0]  kind_t;
    typedef logic [POLICY_BITS-1:0] policy_t;

    // item kinds
    localparam kind_t KIND_SUBMIT   = 2'd0;
    localparam kind_t KIND_COMPLETE = 2'd1;
    localparam kind_t KIND_DISPATCH = 2'd2;

    // policy codes, the unused code behaves as first come first served
    localparam policy_t POLICY_FCFS  = 2'd0;
    localparam policy_t POLICY_SSTF  = 2'd1;
    localparam policy_t POLICY_CSCAN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS = 1'd1;

    typedef struct packed {
        block_t blk;
        logic   write;
        tag_t   tag;
    } drs_entry_t;

    localparam int ENTRY_BITS = $bits(drs_entry_t);

    // result of the shared seek unit
    typedef struct packed {
        block_t mag;
        logic   above;
    } seek_t;

    typedef struct packed {
        logic                accepted;
        logic                dispatched;
        block_t              disp_block;
        logic                disp_write;
        tag_t                disp_tag;
        logic                finished;
        tag_t                finished_tag;
        block_t              head_now;
        logic [SUM_BITS-1:0] seek_total;
        logic [CNT_BITS-1:0] pending_count;
    } drs_result_t;

endpackage
`default_nettype wire

/* rtl/core/drs_in_if.sv */
// drs_in_if: input item channel of the disk request scheduler
`default_nettype none
interface drs_in_if;
    import drs_pkg::*;

    logic   valid;
    logic   ready;
    kind_t  kind;
    block_t req_block;
    logic   req_write;
    tag_t   req_tag;

    modport source (output valid, output kind, output req_block, output req_write,
                    output req_tag, input ready);
    modport sink (input valid, input kind, input req_block, input req_write,
                  input req_tag, output ready);
endinterface
`default_nettype wire

/* rtl/core/drs_out_if.sv */
// drs_out_if: result item channel of the disk request scheduler
`default_nettype none
interface drs_out_if;
    import drs_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic                dispatched;
    block_t              disp_block;
    logic                disp_write;
    tag_t                disp_tag;
    logic                finished;
    tag_t                finished_tag;
    block_t              head_now;
    logic [SUM_BITS-1:0] seek_total;
    logic [CNT_BITS-1:0] pending_count;

    modport source (output valid, output accepted, output dispatched, output disp_block,
                    output disp_write, output disp_tag, output finished,
                    output finished_tag, output head_now, output seek_total,
                    output pending_count, input ready);
    modport sink (input valid, input accepted, input dispatched, input disp_block,
                  input disp_write, input disp_tag, input finished, input finished_tag,
                  input head_now, input seek_total, input pending_count, output ready);
endinterface
`default_nettype wire

/* rtl/core/drs_ram.sv */
// drs_ram: generic single write port ram with registered read
`default_nettype none
module drs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/drs_seek_unit.sv */
// drs_seek_unit: shared distance unit, magnitude of a minus b and a strictly above b
`default_nettype none
module drs_seek_unit (
    input  wire drs_pkg::block_t a,
    input  wire drs_pkg::block_t b,
    output drs_pkg::seek_t       res
);
    import drs_pkg::*;

    logic [BLOCK_BITS:0] diff;

    always_comb
    begin
        diff      = {1'b0, a} - {1'b0, b};
        // negative difference flips to its two's complement magnitude
        res.mag   = diff[BLOCK_BITS] ? BLOCK_BITS'(~diff[BLOCK_BITS-1:0] + 1'b1)
                                     : diff[BLOCK_BITS-1:0];
        res.above = !diff[BLOCK_BITS] && (diff[BLOCK_BITS-1:0] != '0);
    end

endmodule
`default_nettype wire

/* rtl/core/disk_request_scheduler.sv */
// disk_request_scheduler: pending request table with fcfs, sstf and c-scan dispatch
//
//  channel   dir   handshake        payload
//  request   in    valid / ready    kind, req_block, req_write, req_tag
//  result    out   valid / ready    accepted .. pending_count, one per item
//  cfg       in    cfg_we only      cfg_index, cfg_data (policy, block count)
//
//  one item at a time: submit, no-op and idle completion go straight to the result;
//  a completion first passes the gap and accumulate states; a dispatch scans, then shifts:
//  the scan reads the table ram once per entry (every entry for sstf and c-scan, only the
//  head for fcfs), the shift moves n - sel - 1 entries down one place, one per cycle
//  rst_n is asynchronous; the table ram is not cleared, only the count
//  the result register holds while result.ready is low; a new item is still taken, but its result waits
`default_nettype none
module disk_request_scheduler (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [drs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [drs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    drs_in_if.sink                                   request,
    drs_out_if.source                                result
);
    import drs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_GAP,
        S_ACCUM,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    policy_t                policy_reg, policy_next;
    logic [BLKCNT_BITS-1:0] blocks_reg, blocks_next;

    // scheduler state
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                busy_reg, busy_next;
    block_t              service_block_reg, service_block_next;
    tag_t                service_tag_reg, service_tag_next;
    block_t              head_reg, head_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    block_t              gap_reg, gap_next;

    // per item result flags
    logic   acc_reg, acc_next;
    logic   disp_reg, disp_next;
    block_t dblk_reg, dblk_next;
    logic   dwr_reg, dwr_next;
    tag_t   dtag_reg, dtag_next;
    logic   fin_reg, fin_next;
    tag_t   ftag_reg, ftag_next;

    // scan pipeline: issue a read, evaluate the entry in the following cycle
    logic [CNT_BITS-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_BITS-1:0] scan_lim_reg, scan_lim_next;
    logic                ev_vld_reg, ev_vld_next;
    logic [IDX_BITS-1:0] ev_idx_reg, ev_idx_next;

    // best by distance (sstf nearest, c-scan nearest above)
    logic                b1_vld_reg, b1_vld_next;
    block_t              b1_dist_reg, b1_dist_next;
    logic [IDX_BITS-1:0] b1_idx_reg, b1_idx_next;
    drs_entry_t          b1_ent_reg, b1_ent_next;
    // lowest block, earliest first (c-scan wrap, fcfs first entry)
    logic                b2_vld_reg, b2_vld_next;
    logic [IDX_BITS-1:0] b2_idx_reg, b2_idx_next;
    drs_entry_t          b2_ent_reg, b2_ent_next;

    // compaction
    logic [CNT_BITS-1:0] sh_rd_reg, sh_rd_next;
    logic                sh_wvld_reg, sh_wvld_next;
    logic [IDX_BITS-1:0] sh_waddr_reg, sh_waddr_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    drs_result_t out_reg, out_next;

    // table ram and shared seek unit
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    drs_entry_t            ram_wdata;
    logic [IDX_BITS-1:0]   ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata_bits;
    drs_entry_t            ram_rdata;
    block_t                seek_a;
    block_t                seek_b;
    seek_t                 seek;

    logic                  accept_in;
    logic [SUM_BITS:0]     sum_wide;
    logic                  take_b1;
    logic [IDX_BITS-1:0]   sel_idx;
    drs_entry_t            sel_ent;

    drs_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = drs_entry_t'(ram_rdata_bits);

    drs_seek_unit u_seek (
        .a   (seek_a),
        .b   (seek_b),
        .res (seek)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign accept_in     = request.valid && request.ready;

    assign result.valid         = out_valid_reg;
    assign result.accepted      = out_reg.accepted;
    assign result.dispatched    = out_reg.dispatched;
    assign result.disp_block    = out_reg.disp_block;
    assign result.disp_write    = out_reg.disp_write;
    assign result.disp_tag      = out_reg.disp_tag;
    assign result.finished      = out_reg.finished;
    assign result.finished_tag  = out_reg.finished_tag;
    assign result.head_now      = out_reg.head_now;
    assign result.seek_total    = out_reg.seek_total;
    assign result.pending_count = out_reg.pending_count;

    always_comb
    begin
        state_next         = state_reg;
        policy_next        = policy_reg;
        blocks_next        = blocks_reg;
        count_next         = count_reg;
        busy_next          = busy_reg;
        service_block_next = service_block_reg;
        service_tag_next   = service_tag_reg;
        head_next          = head_reg;
        sum_next           = sum_reg;
        gap_next           = gap_reg;
        acc_next           = acc_reg;
        disp_next          = disp_reg;
        dblk_next          = dblk_reg;
        dwr_next           = dwr_reg;
        dtag_next          = dtag_reg;
        fin_next           = fin_reg;
        ftag_next          = ftag_reg;
        rd_idx_next        = rd_idx_reg;
        scan_lim_next      = scan_lim_reg;
        ev_vld_next        = ev_vld_reg;
        ev_idx_next        = ev_idx_reg;
        b1_vld_next        = b1_vld_reg;
        b1_dist_next       = b1_dist_reg;
        b1_idx_next        = b1_idx_reg;
        b1_ent_next        = b1_ent_reg;
        b2_vld_next        = b2_vld_reg;
        b2_idx_next        = b2_idx_reg;
        b2_ent_next        = b2_ent_reg;
        sh_rd_next         = sh_rd_reg;
        sh_wvld_next       = sh_wvld_reg;
        sh_waddr_next      = sh_waddr_reg;
        out_valid_next     = out_valid_reg;
        out_next           = out_reg;

        ram_we    = 1'b0;
        ram_waddr = sh_waddr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_reg[IDX_BITS-1:0];
        seek_a    = ram_rdata.blk;
        seek_b    = head_reg;
        sum_wide  = {1'b0, sum_reg} + (SUM_BITS + 1)'(gap_reg);

        // sstf always takes the nearest; c-scan takes nearest above if any
        take_b1 = (policy_reg == POLICY_SSTF) || ((policy_reg == POLICY_CSCAN) && b1_vld_reg);
        sel_idx = take_b1 ? b1_idx_reg : b2_idx_reg;
        sel_ent = take_b1 ? b1_ent_reg : b2_ent_reg;

        // configuration writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            if (cfg_index == CFG_POLICY)
            begin
                policy_next = cfg_data[POLICY_BITS-1:0];
            end
            else if (cfg_index == CFG_BLOCKS)
            begin
                blocks_next = cfg_data[BLKCNT_BITS-1:0];
            end
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    acc_next   = 1'b0;
                    disp_next  = 1'b0;
                    dblk_next  = '0;
                    dwr_next   = 1'b0;
                    dtag_next  = '0;
                    fin_next   = 1'b0;
                    ftag_next  = '0;
                    state_next = S_DONE;
                    case (request.kind)
                        KIND_SUBMIT:
                        begin
                            // store only with room and an in-range block
                            if ((count_reg < CNT_BITS'(QUEUE_DEPTH)) &&
                                (CMP_BITS'(request.req_block) < CMP_BITS'(blocks_reg)))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_BITS-1:0];
                                ram_wdata  = '{blk: request.req_block,
                                               write: request.req_write,
                                               tag: request.req_tag};
                                count_next = count_reg + 1'b1;
                                acc_next   = 1'b1;
                            end
                        end
                        KIND_COMPLETE:
                        begin
                            if (busy_reg)
                            begin
                                state_next = S_GAP;
                            end
                        end
                        KIND_DISPATCH:
                        begin
                            if (!busy_reg && (count_reg != '0))
                            begin
                                rd_idx_next = '0;
                                // fcfs only looks at the head of the table
                                scan_lim_next = ((policy_reg == POLICY_SSTF) ||
                                                 (policy_reg == POLICY_CSCAN)) ?
                                                count_reg : CNT_BITS'(1);
                                ev_vld_next = 1'b0;
                                b1_vld_next = 1'b0;
                                b2_vld_next = 1'b0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read issue
                if (rd_idx_reg < scan_lim_reg)
                begin
                    ram_raddr   = rd_idx_reg[IDX_BITS-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                    ev_vld_next = 1'b1;
                    ev_idx_next = rd_idx_reg[IDX_BITS-1:0];
                end
                else
                begin
                    ev_vld_next = 1'b0;
                end

                // evaluate the entry read last cycle, strict compares keep the earliest
                if (ev_vld_reg)
                begin
                    if (((policy_reg == POLICY_SSTF) ||
                         ((policy_reg == POLICY_CSCAN) && seek.above)) &&
                        (!b1_vld_reg || (seek.mag < b1_dist_reg)))
                    begin
                        b1_vld_next  = 1'b1;
                        b1_dist_next = seek.mag;
                        b1_idx_next  = ev_idx_reg;
                        b1_ent_next  = ram_rdata;
                    end
                    if (!b2_vld_reg || (ram_rdata.blk < b2_ent_reg.blk))
                    begin
                        b2_vld_next = 1'b1;
                        b2_idx_next = ev_idx_reg;
                        b2_ent_next = ram_rdata;
                    end
                end

                // scan drained: pick and put the request in service
                if ((rd_idx_reg == scan_lim_reg) && !ev_vld_reg)
                begin
                    disp_next          = 1'b1;
                    dblk_next          = sel_ent.blk;
                    dwr_next           = sel_ent.write;
                    dtag_next          = sel_ent.tag;
                    service_block_next = sel_ent.blk;
                    service_tag_next   = sel_ent.tag;
                    sh_rd_next         = CNT_BITS'(sel_idx) + 1'b1;
                    sh_wvld_next       = 1'b0;
                    state_next         = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // entry read last cycle lands one place lower
                if (sh_wvld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_waddr_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_rd_reg < count_reg)
                begin
                    ram_raddr     = sh_rd_reg[IDX_BITS-1:0];
                    sh_rd_next    = sh_rd_reg + 1'b1;
                    sh_wvld_next  = 1'b1;
                    sh_waddr_next = sh_rd_reg[IDX_BITS-1:0] - IDX_BITS'(1);
                end
                else
                begin
                    sh_wvld_next = 1'b0;
                    if (!sh_wvld_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        busy_next  = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_GAP:
            begin
                // distance from head to the block in service
                seek_a     = head_reg;
                seek_b     = service_block_reg;
                gap_next   = seek.mag;
                state_next = S_ACCUM;
            end

            S_ACCUM:
            begin
                // saturating step total
                sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
                head_next  = service_block_reg;
                busy_next  = 1'b0;
                fin_next   = 1'b1;
                ftag_next  = service_tag_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.accepted      = acc_reg;
                    out_next.dispatched    = disp_reg;
                    out_next.disp_block    = dblk_reg;
                    out_next.disp_write    = dwr_reg;
                    out_next.disp_tag      = dtag_reg;
                    out_next.finished      = fin_reg;
                    out_next.finished_tag  = ftag_reg;
                    out_next.head_now      = head_reg;
                    out_next.seek_total    = sum_reg;
                    out_next.pending_count = count_reg;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            policy_reg        <= POLICY_FCFS;
            blocks_reg        <= BLKCNT_BITS'(65536);
            count_reg         <= '0;
            busy_reg          <= 1'b0;
            service_block_reg <= '0;
            service_tag_reg   <= '0;
            head_reg          <= '0;
            sum_reg           <= '0;
            gap_reg           <= '0;
            acc_reg           <= 1'b0;
            disp_reg          <= 1'b0;
            dblk_reg          <= '0;
            dwr_reg           <= 1'b0;
            dtag_reg          <= '0;
            fin_reg           <= 1'b0;
            ftag_reg          <= '0;
            rd_idx_reg        <= '0;
            scan_lim_reg      <= '0;
            ev_vld_reg        <= 1'b0;
            ev_idx_reg        <= '0;
            b1_vld_reg        <= 1'b0;
            b1_dist_reg       <= '0;
            b1_idx_reg        <= '0;
            b1_ent_reg        <= '0;
            b2_vld_reg        <= 1'b0;
            b2_idx_reg        <= '0;
            b2_ent_reg        <= '0;
            sh_rd_reg         <= '0;
            sh_wvld_reg       <= 1'b0;
            sh_waddr_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            policy_reg        <= policy_next;
            blocks_reg        <= blocks_next;
            count_reg         <= count_next;
            busy_reg          <= busy_next;
            service_block_reg <= service_block_next;
            service_tag_reg   <= service_tag_next;
            head_reg          <= head_next;
            sum_reg           <= sum_next;
            gap_reg           <= gap_next;
            acc_reg           <= acc_next;
            disp_reg          <= disp_next;
            dblk_reg          <= dblk_next;
            dwr_reg           <= dwr_next;
            dtag_reg          <= dtag_next;
            fin_reg           <= fin_next;
            ftag_reg          <= ftag_next;
            rd_idx_reg        <= rd_idx_next;
            scan_lim_reg      <= scan_lim_next;
            ev_vld_reg        <= ev_vld_next;
            ev_idx_reg        <= ev_idx_next;
            b1_vld_reg        <= b1_vld_next;
            b1_dist_reg       <= b1_dist_next;
            b1_idx_reg        <= b1_idx_next;
            b1_ent_reg        <= b1_ent_next;
            b2_vld_reg        <= b2_vld_next;
            b2_idx_reg        <= b2_idx_next;
            b2_ent_reg        <= b2_ent_next;
            sh_rd_reg         <= sh_rd_next;
            sh_wvld_reg       <= sh_wvld_next;
            sh_waddr_reg      <= sh_waddr_next;
            out_valid_reg     <= out_valid_next;
            out_reg           <= out_next;
        end
    end

`ifndef SYNTHESIS
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("pending count above table depth");

    // a scanned entry always lies inside the filled part of the table
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && ev_vld_reg |-> CNT_BITS'(ev_idx_reg) < count_reg)
        else $error("scan evaluated an entry beyond the table fill");

    // compaction writes stay below the fill
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && sh_wvld_reg |-> CNT_BITS'(sh_waddr_reg) < count_reg)
        else $error("compaction wrote beyond the table fill");

    // an item never both dispatches and retires
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.dispatched && out_reg.finished))
        else $error("result both dispatched and finished");

    // a dispatch leaves the disk busy with one entry fewer
    a_dispatch_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && (state_next == S_DONE)
        |=> busy_reg && (count_reg == $past(count_reg) - 1'b1))
        else $error("dispatch did not update busy and count");
`endif

endmodule
`default_nettype wire
